// ===== hw/rtl/sorted_priority_ready_queue_macros.svh =====
// assertion macros for the sorted priority ready queue
`ifndef SORTED_PRIORITY_READY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_READY_QUEUE_MACROS_SVH

// checked at every edge, reset included
`define SPQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

// checked outside reset only
`define SPQ_ASSERT(label, prop, msg) \
  `SPQ_ASSERT_ALWAYS(label, disable iff (rst) prop, msg)

`endif

// ===== hw/rtl/spq_pkg.sv =====
// shared types and constants of the sorted priority ready queue
package spq_pkg;

  localparam int DEPTH_DEF     = 64;
  localparam int ID_BITS_DEF   = 16;
  localparam int PRIO_BITS_DEF = 8;
  localparam int STATUS_BITS   = 2;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  typedef enum logic [STATUS_BITS-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PRIME,
    S_SCAN,
    S_PLACE,
    S_REM_RD,
    S_REM_DATA,
    S_DONE
  } state_t;

endpackage

// ===== hw/rtl/spq_if.sv =====
// request and result channel interfaces of the sorted priority ready queue
interface spq_in_if
  import spq_pkg::*;
#(
  parameter int ID_BITS   = ID_BITS_DEF,
  parameter int PRIO_BITS = PRIO_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic                 cmd;
  logic [ID_BITS-1:0]   proc_id;
  logic [PRIO_BITS-1:0] priority_req;

  modport source (output valid, cmd, proc_id, priority_req, input ready);
  modport sink   (input valid, cmd, proc_id, priority_req, output ready);
endinterface

interface spq_out_if
  import spq_pkg::*;
#(
  parameter int ID_BITS   = ID_BITS_DEF,
  parameter int PRIO_BITS = PRIO_BITS_DEF,
  parameter int CNT_BITS  = $clog2(DEPTH_DEF + 1)
);
  logic                   valid;
  logic                   ready;
  logic [STATUS_BITS-1:0] status;
  logic [ID_BITS-1:0]     out_id;
  logic [PRIO_BITS-1:0]   out_priority;
  logic [CNT_BITS-1:0]    occupancy;

  modport source (output valid, status, out_id, out_priority, occupancy, input ready);
  modport sink   (input valid, status, out_id, out_priority, occupancy, output ready);
endinterface

// ===== hw/rtl/spq_ram.sv =====
// entry store: one write port, one read port with registered data
module spq_ram
  import spq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int WIDTH = ID_BITS_DEF + PRIO_BITS_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/sorted_priority_ready_queue.sv =====
// Sorted priority ready queue, top level.
// in_ch carries requests: cmd insert with proc_id and priority_req, or cmd remove.
// out_ch returns one result per request: status, out_id, out_priority and the
// occupancy left after the request. Entries leave in ascending priority number,
// equal numbers in arrival order.
// Entries sit in a circular buffer in one RAM; remove reads the front slot and
// moves the head, passing through S_REM_RD and S_REM_DATA to S_DONE.
// Insert walks back from the tail one slot a cycle through the single RAM read
// port and priority compare, moving each larger entry up one place, and stops at
// the first entry that is not larger, then loads the result in S_DONE. An insert
// into an empty queue goes straight to S_PLACE; a rejected insert or a remove
// on an empty queue goes straight to S_DONE.
// One request is in work at a time; in_ch.ready is high only when idle, so the
// next request can be taken in the cycle after the result is loaded.
// The result register lets the next request enter while a result waits for
// out_ch.ready; a stalled receiver holds the finished request at its last step.
// Reset empties the queue at once; RAM contents need no clearing.
`include "sorted_priority_ready_queue_macros.svh"
module sorted_priority_ready_queue
  import spq_pkg::*;
#(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int ID_BITS   = ID_BITS_DEF,
  parameter int PRIO_BITS = PRIO_BITS_DEF
) (
  input logic        clk,
  input logic        rst,
  spq_in_if.sink     in_ch,
  spq_out_if.source  out_ch
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = ID_BITS + PRIO_BITS;
  localparam logic [AW:0]   DEPTH_A = (AW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  state_t state, state_next;

  logic [CW-1:0]        count;
  logic [AW-1:0]        head;
  logic [AW-1:0]        idx;
  logic [ID_BITS-1:0]   new_id;
  logic [PRIO_BITS-1:0] new_prio;

  status_t              res_status;
  logic [ID_BITS-1:0]   res_id;
  logic [PRIO_BITS-1:0] res_prio;

  logic                 ov;
  status_t              o_status;
  logic [ID_BITS-1:0]   o_id;
  logic [PRIO_BITS-1:0] o_prio;
  logic [CW-1:0]        o_occ;

  logic          we;
  logic [AW-1:0] waddr;
  logic [EW-1:0] wdata;
  logic [AW-1:0] raddr;
  logic [EW-1:0] rdata;

  logic in_acc, shift, load_out;

  // logical position to RAM address
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base, input logic [AW:0] ofs);
    logic [AW:0] sum;
    sum = {1'b0, base} + ofs;
    if (sum >= DEPTH_A) begin
      sum = sum - DEPTH_A;
    end
    return sum[AW-1:0];
  endfunction

  spq_ram #(.DEPTH(DEPTH), .WIDTH(EW)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign in_ch.ready = (state == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign shift       = new_prio < rdata[PRIO_BITS-1:0];
  assign load_out    = (state == S_DONE) && (!ov || out_ch.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    we         = 1'b0;
    waddr      = head;
    wdata      = {new_id, new_prio};
    raddr      = head;
    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          if (in_ch.cmd == CMD_INSERT) begin
            if (count == DEPTH_C) begin
              state_next = S_DONE;
            end else if (count == '0) begin
              state_next = S_PLACE;
            end else begin
              state_next = S_PRIME;
            end
          end else begin
            state_next = (count == '0) ? S_DONE : S_REM_RD;
          end
        end
      end
      S_PRIME: begin
        raddr      = phys(head, {1'b0, idx});
        state_next = S_SCAN;
      end
      S_SCAN: begin
        we    = 1'b1;
        waddr = phys(head, {1'b0, idx} + 1'b1);
        if (shift) begin
          wdata = rdata;
          if (idx == '0) begin
            state_next = S_PLACE;
          end else begin
            raddr = phys(head, {1'b0, idx} - 1'b1);
          end
        end else begin
          state_next = S_DONE;
        end
      end
      S_PLACE: begin
        we         = 1'b1;
        state_next = S_DONE;
      end
      S_REM_RD: begin
        state_next = S_REM_DATA;
      end
      S_REM_DATA: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (load_out) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      head  <= '0;
    end else begin
      if (((state == S_SCAN) && !shift) || (state == S_PLACE)) begin
        count <= count + 1'b1;
      end
      if (state == S_REM_DATA) begin
        count <= count - 1'b1;
        head  <= phys(head, (AW + 1)'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      new_id     <= in_ch.proc_id;
      new_prio   <= in_ch.priority_req;
      idx        <= AW'(count - 1'b1);
      res_id     <= '0;
      res_prio   <= '0;
      if ((in_ch.cmd == CMD_INSERT) && (count == DEPTH_C)) begin
        res_status <= STATUS_FULL;
      end else if ((in_ch.cmd == CMD_REMOVE) && (count == '0)) begin
        res_status <= STATUS_EMPTY;
      end else begin
        res_status <= STATUS_OK;
      end
    end
    if ((state == S_SCAN) && shift) begin
      idx <= idx - 1'b1;
    end
    if (state == S_REM_DATA) begin
      res_id   <= rdata[EW-1:PRIO_BITS];
      res_prio <= rdata[PRIO_BITS-1:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (load_out) begin
      ov <= 1'b1;
    end else if (out_ch.ready) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      o_status <= res_status;
      o_id     <= res_id;
      o_prio   <= res_prio;
      o_occ    <= count;
    end
  end

  assign out_ch.valid        = ov;
  assign out_ch.status       = o_status;
  assign out_ch.out_id       = o_id;
  assign out_ch.out_priority = o_prio;
  assign out_ch.occupancy    = o_occ;

  `SPQ_ASSERT(a_count_bound, (count <= DEPTH_C), "occupancy beyond depth")
  `SPQ_ASSERT(a_busy_after_accept, (in_acc |=> !in_ch.ready), "ready while request in work")
  `SPQ_ASSERT(a_full_occ, (out_ch.valid && (out_ch.status == STATUS_FULL) |-> out_ch.occupancy == DEPTH_C), "full status with room left")
  `SPQ_ASSERT(a_empty_occ, (out_ch.valid && (out_ch.status == STATUS_EMPTY) |-> out_ch.occupancy == '0), "empty status with entries held")

endmodule
